>>> rtl/moc_pkg.sv
// Shared types, constants and the divide-by-255 helper for the masked overlay
// compositor. No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package moc_pkg;

  localparam int unsigned NumCh = 3;

  typedef logic [7:0]  chan_t;
  typedef logic [15:0] prod_t;

  localparam chan_t ChMax = 8'd255;

  // One input transfer, as seen by the first stage.
  typedef struct packed {
    logic             mode;
    chan_t [NumCh-1:0] bg;
    chan_t [NumCh-1:0] ov;
    chan_t            alpha;
    chan_t [NumCh-1:0] mask;
  } pix_in_t;

  // Hand-off from the over stages to the mix stages.
  typedef struct packed {
    logic             mode;
    chan_t [NumCh-1:0] bg;
    chan_t [NumCh-1:0] c;
    chan_t            m;
  } mid_t;

  // Exact floor(x / 255) for x <= 255*255: (x + (x >> 8) + 1) >> 8.
  function automatic chan_t div255(prod_t x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> rtl/moc_in_if.sv
// Input channel of the compositor: valid/ready plus one pixel triple.
// Depends on moc_pkg for the channel type.
`timescale 1ns / 1ps

interface moc_in_if;
  import moc_pkg::*;

  logic  valid;
  logic  ready;
  logic  mode;
  chan_t background_ch0;
  chan_t background_ch1;
  chan_t background_ch2;
  chan_t overlay_ch0;
  chan_t overlay_ch1;
  chan_t overlay_ch2;
  chan_t overlay_alpha;
  chan_t mask_ch0;
  chan_t mask_ch1;
  chan_t mask_ch2;

  modport source (
    output valid, mode, background_ch0, background_ch1, background_ch2,
           overlay_ch0, overlay_ch1, overlay_ch2, overlay_alpha,
           mask_ch0, mask_ch1, mask_ch2,
    input  ready
  );

  modport sink (
    input  valid, mode, background_ch0, background_ch1, background_ch2,
           overlay_ch0, overlay_ch1, overlay_ch2, overlay_alpha,
           mask_ch0, mask_ch1, mask_ch2,
    output ready
  );
endinterface

>>> rtl/moc_out_if.sv
// Output channel of the compositor: valid/ready plus one composited pixel.
// Depends on moc_pkg for the channel type.
`timescale 1ns / 1ps

interface moc_out_if;
  import moc_pkg::*;

  logic  valid;
  logic  ready;
  chan_t result_ch0;
  chan_t result_ch1;
  chan_t result_ch2;

  modport source (
    output valid, result_ch0, result_ch1, result_ch2,
    input  ready
  );

  modport sink (
    input  valid, result_ch0, result_ch1, result_ch2,
    output ready
  );
endinterface

>>> rtl/masked_overlay_compositor.sv
// Top level of the masked overlay compositor: binds the channel interfaces to
// the over and mix pipeline halves. Depends on moc_pkg, moc_in_if, moc_out_if.
`timescale 1ns / 1ps

// One pixel per transfer in, one composited pixel per transfer out, one pixel
// per clock sustained while the output is accepted. In flight, stage A forms
// (255 - alpha) * background and the largest mask channel, stage B divides by
// 255 and adds the saturated overlay, stage C forms bg*(255-m) + c*m, stage D
// divides by 255 and registers the result (plain mode passes c instead).
// Every stage has its own valid bit and loads whenever it is empty or its
// successor loads, so bubbles collapse and input is taken while a finished
// pixel waits on the output. All divisions are exact floor by 255.
module masked_overlay_compositor (
  input  logic      clk_i,
  input  logic      rst_ni,
  moc_in_if.sink    pix_i,
  moc_out_if.source res_o
);
  import moc_pkg::*;

  pix_in_t           pix_in;
  mid_t              mid;
  logic              mid_valid;
  logic              mid_ready;
  chan_t [NumCh-1:0] res;

  // Pack the channel fields into the stage payload.
  assign pix_in.mode    = pix_i.mode;
  assign pix_in.bg      = {pix_i.background_ch2, pix_i.background_ch1, pix_i.background_ch0};
  assign pix_in.ov      = {pix_i.overlay_ch2, pix_i.overlay_ch1, pix_i.overlay_ch0};
  assign pix_in.alpha   = pix_i.overlay_alpha;
  assign pix_in.mask    = {pix_i.mask_ch2, pix_i.mask_ch1, pix_i.mask_ch0};

  moc_over u_over (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .pix_i   (pix_in),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .mid_o   (mid)
  );

  moc_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .mid_i   (mid),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res)
  );

  // Unpack the result register onto the output channel.
  assign res_o.result_ch0 = res[0];
  assign res_o.result_ch1 = res[1];
  assign res_o.result_ch2 = res[2];

endmodule

>>> rtl/moc_over.sv
// Over stages: background scaling by (255 - alpha), divide by 255, add overlay
// and saturate; also picks the largest mask channel. Depends on moc_pkg.
`timescale 1ns / 1ps

module moc_over (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  moc_pkg::pix_in_t pix_i,
  output logic             valid_o,
  input  logic             ready_i,
  output moc_pkg::mid_t    mid_o
);
  import moc_pkg::*;

  // Stage A: products and mask maximum.
  logic              va_q;
  logic              mode_a_q;
  chan_t [NumCh-1:0] bg_a_q;
  chan_t [NumCh-1:0] ov_a_q;
  prod_t [NumCh-1:0] prod_a_q;
  chan_t             m_a_q;

  // Stage B: saturated over result.
  logic              vb_q;
  mid_t              mid_b_q;

  logic  en_a;
  logic  en_b;
  chan_t inv_alpha;
  chan_t m01;
  chan_t m_max;

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  assign inv_alpha = ChMax - pix_i.alpha;
  assign m01       = (pix_i.mask[1] > pix_i.mask[0]) ? pix_i.mask[1] : pix_i.mask[0];
  assign m_max     = (pix_i.mask[2] > m01) ? pix_i.mask[2] : m01;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      mode_a_q <= pix_i.mode;
      bg_a_q   <= pix_i.bg;
      ov_a_q   <= pix_i.ov;
      m_a_q    <= m_max;
      for (int k = 0; k < NumCh; k++) begin
        prod_a_q[k] <= {8'd0, inv_alpha} * {8'd0, pix_i.bg[k]};
      end
    end
  end

  // Divide by 255, add overlay, clamp at full scale.
  mid_t        mid_b_d;
  logic [8:0]  sum_b [NumCh];

  always_comb begin
    mid_b_d.mode = mode_a_q;
    mid_b_d.bg   = bg_a_q;
    mid_b_d.m    = m_a_q;
    for (int k = 0; k < NumCh; k++) begin
      sum_b[k]      = {1'b0, div255(prod_a_q[k])} + {1'b0, ov_a_q[k]};
      mid_b_d.c[k]  = sum_b[k][8] ? ChMax : sum_b[k][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) mid_b_q <= mid_b_d;
  end

  assign valid_o = vb_q;
  assign mid_o   = mid_b_q;

endmodule

>>> rtl/moc_mix.sv
// Mix stages: blend background and over result by mask weight, divide by 255
// (plain mode: pass over result), hold output register. Depends on moc_pkg.
`timescale 1ns / 1ps

module moc_mix (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  moc_pkg::mid_t                mid_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output moc_pkg::chan_t [moc_pkg::NumCh-1:0] res_o
);
  import moc_pkg::*;

  // Stage C: weighted sum.
  logic              vc_q;
  logic              mode_c_q;
  chan_t [NumCh-1:0] c_c_q;
  prod_t [NumCh-1:0] sum_c_q;

  // Stage D: result register.
  logic              vd_q;
  chan_t [NumCh-1:0] res_d_q;

  logic  en_c;
  logic  en_d;
  chan_t inv_m;

  assign en_d    = !vd_q || ready_i;
  assign en_c    = !vc_q || en_d;
  assign ready_o = en_c;

  assign inv_m = ChMax - mid_i.m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (en_c) vc_q <= valid_i;
      if (en_d) vd_q <= vc_q;
    end
  end

  // bg*(255-m) + c*m never exceeds 255*255, so 16 bits hold it.
  always_ff @(posedge clk_i) begin
    if (en_c && valid_i) begin
      mode_c_q <= mid_i.mode;
      c_c_q    <= mid_i.c;
      for (int k = 0; k < NumCh; k++) begin
        sum_c_q[k] <= prod_t'(inv_m * mid_i.bg[k]) + prod_t'(mid_i.m * mid_i.c[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d && vc_q) begin
      for (int k = 0; k < NumCh; k++) begin
        res_d_q[k] <= mode_c_q ? div255(sum_c_q[k]) : c_c_q[k];
      end
    end
  end

  assign valid_o = vd_q;
  assign res_o   = res_d_q;

endmodule
